@@ design/assert_macros.svh @@
// Shared assertion macros for the target locator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("locator property violated");

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("locator forbidden condition seen");

`endif

@@ design/ggtl_pkg.sv @@
package ggtl_pkg;

  // Number of CORDIC steps per angle; the arctangent table has 24 entries.
  localparam int ROTATION_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                : ROTATION_STEPS;
  localparam int DIV_BITS = 48;
  localparam int CNT_W = 6;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  localparam logic [14:0] NORM_LOW_RESET = 15'd14746;
  localparam logic [14:0] NORM_HIGH_RESET = 15'd18022;

  // Configuration register indexes.
  localparam logic REG_NORM_LOW = 1'b0;
  localparam logic REG_NORM_HIGH = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CINIT = 8'b0000_0010,
    S_CSTEP = 8'b0000_0100,
    S_ROT   = 8'b0000_1000,
    S_NORM  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_TGT   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [3:0] {
    MS_NONE,
    MS_CP,
    MS_SQ,
    MS_SP,
    MS_CQ,
    MS_XX,
    MS_YY,
    MS_ZZ,
    MS_LOW,
    MS_HIGH,
    MS_HRX,
    MS_HRY
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic       capture;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] step;
    logic [2:0] ang_idx;
    mul_sel_t   mul_sel;
    acc_op_t    acc_op;
    logic       save_np;
    logic       write_pair;
    logic       save_lo;
    logic       save_hi;
    logic       eval_ok;
    logic       div_start;
    logic       div_step;
    logic       div_save;
    logic       div_y;
    logic       tgt_x;
    logic       tgt_y;
  } cmd_t;

  typedef struct packed {
    logic ok;
  } status_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [29:0] atan_lookup(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

@@ design/ggtl_ctrl.sv @@
`include "assert_macros.svh"

module ggtl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ggtl_pkg::status_t status,
  output ggtl_pkg::cmd_t    cmd
);
  import ggtl_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [2:0]       ang_idx, ang_idx_next;
  logic             div_y, div_y_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  // Sequencing and command decode.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ang_idx_next = ang_idx;
    div_y_next = div_y;
    cmd = '0;
    cmd.mul_sel = MS_NONE;
    cmd.acc_op = ACC_HOLD;
    cmd.ang_idx = ang_idx;
    cmd.div_y = div_y;
    cmd.step = cnt[4:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ang_idx_next = 3'd0;
          state_next = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next = '0;
        state_next = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cordic_step = 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_next = '0;
          state_next = S_ROT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROT: begin
        cnt_next = cnt + 1'b1;
        case (cnt)
          6'd0: cmd.mul_sel = MS_CP;
          6'd1: begin
            cmd.acc_op = ACC_LOAD;
            cmd.mul_sel = MS_SQ;
          end
          6'd2: begin
            cmd.acc_op = ACC_SUB;
            cmd.mul_sel = MS_SP;
          end
          6'd3: begin
            cmd.save_np = 1'b1;
            cmd.acc_op = ACC_LOAD;
            cmd.mul_sel = MS_CQ;
          end
          6'd4: cmd.acc_op = ACC_ADD;
          default: begin
            cmd.write_pair = 1'b1;
            cnt_next = '0;
            if (ang_idx == 3'd4) begin
              state_next = S_NORM;
            end else begin
              ang_idx_next = ang_idx + 1'b1;
              state_next = S_CINIT;
            end
          end
        endcase
      end
      S_NORM: begin
        cnt_next = cnt + 1'b1;
        case (cnt)
          6'd0: cmd.mul_sel = MS_XX;
          6'd1: begin
            cmd.acc_op = ACC_LOAD;
            cmd.mul_sel = MS_YY;
          end
          6'd2: begin
            cmd.acc_op = ACC_ADD;
            cmd.mul_sel = MS_ZZ;
          end
          6'd3: begin
            cmd.acc_op = ACC_ADD;
            cmd.mul_sel = MS_LOW;
          end
          6'd4: begin
            cmd.save_lo = 1'b1;
            cmd.mul_sel = MS_HIGH;
          end
          6'd5: cmd.save_hi = 1'b1;
          6'd6: cmd.eval_ok = 1'b1;
          default: begin
            cnt_next = '0;
            div_y_next = 1'b0;
            state_next = status.ok ? S_DIV : S_TGT;
          end
        endcase
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == '0) begin
          cmd.div_start = 1'b1;
        end else if (cnt <= CNT_W'(DIV_BITS)) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_save = 1'b1;
          cnt_next = '0;
          if (div_y) begin
            state_next = S_TGT;
          end else begin
            div_y_next = 1'b1;
          end
        end
      end
      S_TGT: begin
        cnt_next = cnt + 1'b1;
        case (cnt)
          6'd0: cmd.mul_sel = MS_HRX;
          6'd1: begin
            cmd.tgt_x = 1'b1;
            cmd.mul_sel = MS_HRY;
          end
          default: begin
            cmd.tgt_y = 1'b1;
            cnt_next = '0;
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ang_idx <= '0;
      div_y <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ang_idx <= ang_idx_next;
      div_y <= div_y_next;
    end
  end

  `ASSERT_CLK(a_out_clears, clk, rst, out_valid && !out_stall |=> !out_valid)
  `ASSERT_CLK(a_busy_after_take, clk, rst, in_valid && !in_stall |=> in_stall)
  `ASSERT_CLK(a_div_needs_ok, clk, rst, state == S_DIV |-> status.ok)

endmodule

@@ design/ggtl_dp.sv @@
`include "assert_macros.svh"

module ggtl_dp (
  input  logic                clk,
  input  logic                rst,
  input  ggtl_pkg::cmd_t      cmd,
  output ggtl_pkg::status_t   status,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [14:0]         cfg_data,
  input  logic signed [15:0]  drone_roll,
  input  logic signed [15:0]  drone_pitch,
  input  logic signed [15:0]  drone_yaw,
  input  logic signed [15:0]  mount_pitch,
  input  logic signed [15:0]  mount_yaw,
  input  logic signed [23:0]  drone_east_cm,
  input  logic signed [23:0]  drone_north_cm,
  input  logic [19:0]         height_cm,
  output logic signed [31:0]  target_east_cm,
  output logic signed [31:0]  target_north_cm,
  output logic                direction_ok,
  output logic                clipped,
  output logic signed [15:0]  look_x,
  output logic signed [15:0]  look_y,
  output logic signed [15:0]  look_z
);
  import ggtl_pkg::*;

  // Item registers; angles in rotation order.
  logic [15:0]        ang [5];
  logic signed [23:0] east, north;
  logic [19:0]        height;
  logic [14:0]        low_b, high_b;
  logic signed [31:0] held_rx, held_ry;

  logic signed [33:0] cx, cy, cz;
  logic signed [31:0] vx, vy, vz, tmp;
  logic signed [65:0] prod, acc;
  logic [29:0]        lo2, hi2;
  logic               ok_r, clip_r;
  logic [31:0]        rem;
  logic [47:0]        quo;
  logic               neg;

  assign status.ok = ok_r;
  assign direction_ok = ok_r;
  assign clipped = clip_r;

  // Angle and rotation pair selection.
  logic [15:0]        ang_sel;
  logic signed [31:0] pv, qv;
  always_comb begin
    case (cmd.ang_idx)
      3'd0: ang_sel = ang[0];
      3'd1: ang_sel = ang[1];
      3'd2: ang_sel = ang[2];
      3'd3: ang_sel = ang[3];
      default: ang_sel = ang[4];
    endcase
    case (cmd.ang_idx)
      3'd1, 3'd4: begin
        pv = vx;
        qv = vy;
      end
      3'd2: begin
        pv = vy;
        qv = vz;
      end
      default: begin
        pv = vz;
        qv = vx;
      end
    endcase
  end

  // CORDIC start point with quadrant fold.
  logic [31:0] a_init;
  logic        fold;
  assign fold = ang_sel[15] ^ ang_sel[14];
  assign a_init = {ang_sel[15] ^ fold, ang_sel[14:0], 16'h0};

  logic signed [33:0] dx, dy, at;
  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;
  assign at = $signed({4'b0, atan_lookup(cmd.step)});

  logic signed [31:0] c_val, s_val;
  assign c_val = cx[31:0];
  assign s_val = cy[31:0];

  // Shared multiplier operands.
  logic signed [32:0] ma, mb;
  always_comb begin
    case (cmd.mul_sel)
      MS_CP: begin ma = {c_val[31], c_val}; mb = {pv[31], pv}; end
      MS_SQ: begin ma = {s_val[31], s_val}; mb = {qv[31], qv}; end
      MS_SP: begin ma = {s_val[31], s_val}; mb = {pv[31], pv}; end
      MS_CQ: begin ma = {c_val[31], c_val}; mb = {qv[31], qv}; end
      MS_XX: begin ma = {vx[31], vx}; mb = {vx[31], vx}; end
      MS_YY: begin ma = {vy[31], vy}; mb = {vy[31], vy}; end
      MS_ZZ: begin ma = {vz[31], vz}; mb = {vz[31], vz}; end
      MS_LOW: begin ma = {18'b0, low_b}; mb = {18'b0, low_b}; end
      MS_HIGH: begin ma = {18'b0, high_b}; mb = {18'b0, high_b}; end
      MS_HRX: begin ma = {13'b0, height}; mb = {held_rx[31], held_rx}; end
      MS_HRY: begin ma = {13'b0, height}; mb = {held_ry[31], held_ry}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [65:0] acc_sh;
  assign acc_sh = acc >>> 30;

  // Norm window and downward test.
  logic [65:0] lo_ext, hi_ext;
  logic        ok_now;
  assign lo_ext = {4'b0, lo2, 32'b0};
  assign hi_ext = {4'b0, hi2, 32'b0};
  assign ok_now = ($unsigned(acc) > lo_ext) && ($unsigned(acc) < hi_ext) &&
                  !vz[31] && (vz != 32'sd0);

  // Divider operand and step.
  logic signed [31:0] vd;
  logic signed [32:0] vd_abs;
  logic [32:0]        trial, diff;
  assign vd = cmd.div_y ? vy : vx;
  assign vd_abs = vd[31] ? -$signed({vd[31], vd}) : $signed({vd[31], vd});
  assign trial = {rem, quo[47]};
  assign diff = trial - {1'b0, vz};

  // Quotient sign and saturation.
  logic signed [31:0] ratio;
  logic               ratio_clip;
  always_comb begin
    ratio_clip = 1'b0;
    if (neg) begin
      if (quo > 48'h0000_8000_0000) begin
        ratio = 32'sh8000_0000;
        ratio_clip = 1'b1;
      end else begin
        ratio = -$signed(quo[31:0]);
      end
    end else begin
      if (quo > 48'h0000_7FFF_FFFF) begin
        ratio = 32'sh7FFF_FFFF;
        ratio_clip = 1'b1;
      end else begin
        ratio = $signed(quo[31:0]);
      end
    end
  end

  // Target sum and saturation.
  logic signed [65:0] prod_sh;
  logic signed [23:0] pos_sel;
  logic signed [37:0] tsum;
  logic signed [31:0] tsat;
  logic               tclip;
  assign prod_sh = prod >>> 16;
  assign pos_sel = cmd.tgt_y ? north : east;
  assign tsum = {{14{pos_sel[23]}}, pos_sel} + prod_sh[37:0];
  always_comb begin
    tclip = (tsum[37:31] != 7'h00) && (tsum[37:31] != 7'h7F);
    if (tclip) begin
      tsat = tsum[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      tsat = tsum[31:0];
    end
  end

  function automatic logic signed [15:0] sat_look(input logic signed [31:0] v);
    logic signed [16:0] t;
    logic signed [15:0] r;
    t = v[31:15];
    if (t > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (t < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // Configuration and held ratios.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_b <= NORM_LOW_RESET;
      high_b <= NORM_HIGH_RESET;
      held_rx <= '0;
      held_ry <= '0;
      ok_r <= 1'b0;
      clip_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NORM_LOW: low_b <= cfg_data;
          REG_NORM_HIGH: high_b <= cfg_data;
          default: low_b <= low_b;
        endcase
      end
      if (cmd.capture) begin
        ok_r <= 1'b0;
        clip_r <= 1'b0;
      end
      if (cmd.eval_ok) begin
        ok_r <= ok_now;
      end
      if (cmd.div_save) begin
        if (cmd.div_y) begin
          held_ry <= ratio;
        end else begin
          held_rx <= ratio;
        end
        if (ratio_clip) begin
          clip_r <= 1'b1;
        end
      end
      if ((cmd.tgt_x || cmd.tgt_y) && tclip) begin
        clip_r <= 1'b1;
      end
    end
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD: acc <= acc + prod;
      ACC_SUB: acc <= acc - prod;
      default: acc <= acc;
    endcase
    if (cmd.capture) begin
      ang[0] <= mount_pitch;
      ang[1] <= mount_yaw;
      ang[2] <= drone_roll;
      ang[3] <= drone_pitch;
      ang[4] <= drone_yaw;
      east <= drone_east_cm;
      north <= drone_north_cm;
      height <= height_cm;
      vx <= ONE_Q30;
      vy <= '0;
      vz <= '0;
    end
    if (cmd.cordic_init) begin
      cx <= fold ? -CORDIC_GAIN : CORDIC_GAIN;
      cy <= '0;
      cz <= {{2{a_init[31]}}, a_init};
    end
    if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
    if (cmd.save_np) begin
      tmp <= acc_sh[31:0];
    end
    if (cmd.write_pair) begin
      case (cmd.ang_idx)
        3'd1, 3'd4: begin
          vx <= tmp;
          vy <= acc_sh[31:0];
        end
        3'd2: begin
          vy <= tmp;
          vz <= acc_sh[31:0];
        end
        default: begin
          vz <= tmp;
          vx <= acc_sh[31:0];
        end
      endcase
    end
    if (cmd.save_lo) begin
      lo2 <= prod[29:0];
    end
    if (cmd.save_hi) begin
      hi2 <= prod[29:0];
    end
    if (cmd.div_start) begin
      neg <= vd[31];
      rem <= '0;
      quo <= {vd_abs[31:0], 16'h0};
    end
    if (cmd.div_step) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
    if (cmd.tgt_x) begin
      target_east_cm <= tsat;
    end
    if (cmd.tgt_y) begin
      target_north_cm <= tsat;
      look_x <= sat_look(vx);
      look_y <= sat_look(vy);
      look_z <= sat_look(vz);
    end
  end

  `ASSERT_CLK(a_held_x_needs_ok, clk, rst, !$stable(held_rx) |-> ok_r)
  `ASSERT_NEVER(a_tgt_overlap, clk, rst, cmd.tgt_x && cmd.tgt_y)

endmodule

@@ design/gimbal_ground_target_locator.sv @@
// Ground target locator for a drone camera gimbal over flat ground.
// Input channel (in_valid / in_stall): five attitude angles as binary angles,
// the drone east and north position and its height. A transfer takes place
// when in_valid is high and in_stall is low. Output channel (out_valid /
// out_stall): target east and north, the direction check flag, the clip flag
// and the rotated look vector, one result per input item.
// The block works on one item at a time. Each of the five angles takes a
// CORDIC start step, CORDIC_STEPS iteration steps (ROTATION_STEPS, capped at
// the 24-entry arctangent table) and a pass on the shared multiplier; the
// norm check follows. When the check passes, two 48-bit restoring divisions
// follow, one quotient bit per cycle. The target is computed last.
// in_stall stays high from a transfer until the result has been taken.
// If the receiver holds out_stall, the result stays on the ports unchanged.
// Synchronous reset clears the held ratios to zero, loads the default norm
// bounds and empties the block. Norm bounds are written through cfg_write,
// cfg_index and cfg_data; write them only while idle (the block does not enforce it).
module gimbal_ground_target_locator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] drone_roll,
  input  logic signed [15:0] drone_pitch,
  input  logic signed [15:0] drone_yaw,
  input  logic signed [15:0] mount_pitch,
  input  logic signed [15:0] mount_yaw,
  input  logic signed [23:0] drone_east_cm,
  input  logic signed [23:0] drone_north_cm,
  input  logic [19:0]        height_cm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] target_east_cm,
  output logic signed [31:0] target_north_cm,
  output logic               direction_ok,
  output logic               clipped,
  output logic signed [15:0] look_x,
  output logic signed [15:0] look_y,
  output logic signed [15:0] look_z
);
  import ggtl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  ggtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  ggtl_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .drone_roll      (drone_roll),
    .drone_pitch     (drone_pitch),
    .drone_yaw       (drone_yaw),
    .mount_pitch     (mount_pitch),
    .mount_yaw       (mount_yaw),
    .drone_east_cm   (drone_east_cm),
    .drone_north_cm  (drone_north_cm),
    .height_cm       (height_cm),
    .target_east_cm  (target_east_cm),
    .target_north_cm (target_north_cm),
    .direction_ok    (direction_ok),
    .clipped         (clipped),
    .look_x          (look_x),
    .look_y          (look_y),
    .look_z          (look_z)
  );

endmodule
